FILE: hw/rtl/glu_pkg.sv
package glu_pkg;

	// operand width the arithmetic runs at (8 to 32)
	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W         = $clog2(OPERAND_WIDTH);
	localparam int ALU_W         = OPERAND_WIDTH + 1;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;

	// fixed field widths on the stream ports
	localparam int IN_FIELD_W  = 32;
	localparam int GCD_W       = 32;
	localparam int LCM_W       = 63;
	localparam int IN_TDATA_W  = 2 * IN_FIELD_W;
	localparam int OUT_TDATA_W = GCD_W + LCM_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TWOS,
		ST_REDUCE,
		ST_SCALE,
		ST_DIV_INIT,
		ST_DIV,
		ST_MUL_INIT,
		ST_MUL,
		ST_DONE
	} seq_state_t;

	typedef enum logic [3:0] {
		OP_HOLD,
		OP_LOAD,
		OP_ZERO,
		OP_TWOS,
		OP_REDUCE,
		OP_SCALE,
		OP_DIV_INIT,
		OP_DIV,
		OP_MUL_INIT,
		OP_MUL,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic op_zero;
		logic both_even;
		logic y_zero;
		logic k_zero;
		logic cnt_last;
	} dp_status_t;

	typedef struct packed {
		logic [ALU_W-1:0] opa;
		logic [ALU_W-1:0] opb;
		logic             sub;
	} alu_req_t;

endpackage

FILE: hw/rtl/glu_alu.sv
module glu_alu
	import glu_pkg::*;
(
	input  alu_req_t         req,
	output logic [ALU_W:0]   res
);

	// top bit is the borrow on subtract, the carry on add
	always_comb begin
		if (req.sub) begin
			res = {1'b0, req.opa} - {1'b0, req.opb};
		end else begin
			res = {1'b0, req.opa} + {1'b0, req.opb};
		end
	end

endmodule

FILE: hw/rtl/glu_dpath.sv
module glu_dpath
	import glu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_op_t                   op,
	input  logic [OPERAND_WIDTH-1:0] first_raw,
	input  logic [OPERAND_WIDTH-1:0] second_raw,
	output dp_status_t               status,
	output logic [OPERAND_WIDTH-1:0] gcd,
	output logic [PROD_W-1:0]        prod
);

	logic [OPERAND_WIDTH-1:0] a_q, b_q, x_q, y_q;
	logic [CNT_W-1:0]         k_q, cnt_q;
	logic [PROD_W-1:0]        acc_q;
	logic [OPERAND_WIDTH-1:0] first_mag, second_mag;
	alu_req_t                 alu_req;
	logic [ALU_W:0]           alu_res;
	logic                     borrow;

	function automatic logic [OPERAND_WIDTH-1:0] magnitude(input logic [OPERAND_WIDTH-1:0] v);
		logic [OPERAND_WIDTH-1:0] m;
		m = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	assign first_mag  = magnitude(first_raw);
	assign second_mag = magnitude(second_raw);

	// operand select for the shared adder
	always_comb begin
		alu_req = '0;
		case (op)
			OP_REDUCE: begin
				alu_req.opa = {1'b0, y_q};
				alu_req.opb = {1'b0, x_q};
				alu_req.sub = 1'b1;
			end
			OP_DIV: begin
				alu_req.opa = acc_q[PROD_W-1:OPERAND_WIDTH-1];
				alu_req.opb = {1'b0, x_q};
				alu_req.sub = 1'b1;
			end
			OP_MUL: begin
				alu_req.opa = {1'b0, acc_q[PROD_W-1:OPERAND_WIDTH]};
				alu_req.opb = acc_q[0] ? {1'b0, b_q} : '0;
				alu_req.sub = 1'b0;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	glu_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign borrow = alu_res[ALU_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (op)
				OP_LOAD:     k_q   <= '0;
				OP_TWOS:     k_q   <= k_q + 1'b1;
				OP_SCALE:    k_q   <= k_q - 1'b1;
				OP_DIV_INIT: cnt_q <= '0;
				OP_MUL_INIT: cnt_q <= '0;
				OP_DIV:      cnt_q <= cnt_q + 1'b1;
				OP_MUL:      cnt_q <= cnt_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				a_q <= first_mag;
				b_q <= second_mag;
				x_q <= first_mag;
				y_q <= second_mag;
			end
			OP_ZERO: begin
				x_q   <= x_q | y_q;
				acc_q <= '0;
			end
			OP_TWOS: begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
			end
			OP_REDUCE: begin
				// shift out factors of two, else swap or subtract
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (borrow) begin
					x_q <= y_q;
					y_q <= x_q;
				end else begin
					y_q <= alu_res[OPERAND_WIDTH-1:0];
				end
			end
			OP_SCALE: begin
				x_q <= x_q << 1;
			end
			OP_DIV_INIT: begin
				acc_q <= {{OPERAND_WIDTH{1'b0}}, a_q};
			end
			OP_DIV: begin
				// restoring step: remainder high, dividend shifting into quotient low
				if (!borrow) begin
					acc_q <= {alu_res[OPERAND_WIDTH-1:0], acc_q[OPERAND_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[PROD_W-2:0], 1'b0};
				end
			end
			OP_MUL_INIT: begin
				acc_q <= {{OPERAND_WIDTH{1'b0}}, acc_q[OPERAND_WIDTH-1:0]};
			end
			OP_MUL: begin
				acc_q <= {alu_res[OPERAND_WIDTH:0], acc_q[OPERAND_WIDTH-1:1]};
			end
			default: begin
			end
		endcase
	end

	assign status.op_zero   = (x_q == '0) || (y_q == '0);
	assign status.both_even = !x_q[0] && !y_q[0];
	assign status.y_zero    = (y_q == '0);
	assign status.k_zero    = (k_q == '0);
	assign status.cnt_last  = (cnt_q == CNT_W'(OPERAND_WIDTH - 1));

	assign gcd  = x_q;
	assign prod = acc_q;

endmodule

FILE: hw/rtl/glu_seq.sv
module glu_seq
	import glu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_free,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_op_t     op
);

	seq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHECK;
			ST_CHECK:    state_d = status.op_zero ? ST_DONE : ST_TWOS;
			ST_TWOS:     if (!status.both_even) state_d = ST_REDUCE;
			ST_REDUCE:   if (status.y_zero) state_d = ST_SCALE;
			ST_SCALE:    if (status.k_zero) state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      if (status.cnt_last) state_d = ST_MUL_INIT;
			ST_MUL_INIT: state_d = ST_MUL;
			ST_MUL:      if (status.cnt_last) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_HOLD;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_LOAD;
			end
			ST_CHECK:    if (status.op_zero) op = OP_ZERO;
			ST_TWOS:     if (status.both_even) op = OP_TWOS;
			ST_REDUCE:   if (!status.y_zero) op = OP_REDUCE;
			ST_SCALE:    if (!status.k_zero) op = OP_SCALE;
			ST_DIV_INIT: op = OP_DIV_INIT;
			ST_DIV:      op = OP_DIV;
			ST_MUL_INIT: op = OP_MUL_INIT;
			ST_MUL:      op = OP_MUL;
			ST_DONE:     if (out_free) op = OP_EMIT;
			default:     op = OP_HOLD;
		endcase
	end

endmodule

FILE: hw/rtl/gcd_lcm_unit.sv
// channel  dir  tdata fields (lowest bit up)                   transfer
// s_*      in   first_value[31:0], second_value[63:32]          one operand pair
// m_*      out  gcd_value[31:0], lcm_value[94:32], lcm_too_big[95]  one result
//
// one transfer in gives one transfer out; W is the operand width
// an item runs through load, check, the binary gcd loop (strip common twos,
// shift/subtract/swap steps, rescale), divide, multiply and emit; one shared
// adder/subtractor does the subtract, divide and multiply steps, so s_tready
// is high only in idle; a zero operand skips the arithmetic and goes from the
// check straight to the done state
// reset clears the sequencer and the output valid; a stalled m_tready holds the
// result in the output register while the next pair is already accepted
module gcd_lcm_unit
	import glu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // first_value, second_value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // gcd_value, lcm_value, lcm_too_big
);

	dp_op_t                   op;
	dp_status_t               status;
	logic                     out_free;
	logic [OPERAND_WIDTH-1:0] gcd;
	logic [PROD_W-1:0]        prod;
	logic                     too_big;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	glu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.status   (status),
		.in_ready (s_tready),
		.op       (op)
	);

	// bits above the operand width are ignored, top operand bit is the sign
	glu_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.first_raw  (s_tdata[OPERAND_WIDTH-1:0]),
		.second_raw (s_tdata[IN_FIELD_W+OPERAND_WIDTH-1:IN_FIELD_W]),
		.status     (status),
		.gcd        (gcd),
		.prod       (prod)
	);

	// lcm exceeds the signed range when anything at or above bit W-1 is set
	assign too_big = |prod[PROD_W-1:OPERAND_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (op == OP_EMIT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT) begin
			m_tdata_q <= {too_big, LCM_W'(prod[PROD_W-2:0]), GCD_W'(gcd)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
